FILE: rtl/rbed_pkg.sv
// shared types, constants and helpers for the ray box entry distance block
package rbed_pkg;

    localparam int AXES       = 3;
    localparam int FACES      = 6;
    localparam int COORD_W    = 32;
    localparam int NMAG_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int DIVD_W     = COORD_W + FRAC_W;
    localparam int DIV_STAGES = DIVD_W;
    localparam int T_W        = DIVD_W + 1;
    localparam int HI_W       = NMAG_W + COORD_W;
    localparam int SUM_W      = HI_W + 1;
    localparam int P_W        = SUM_W + 2;
    localparam int OUT_W      = 27;
    localparam int S_TDATA_W  = 2 * AXES * COORD_W;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int BIT_CNT_W  = 5;

    localparam logic [OUT_W-1:0]  SENTINEL = 27'd104857600;
    localparam logic [NMAG_W-1:0] UNIT     = 17'd65536;
    localparam logic [BIT_CNT_W-1:0] TOP_BIT = BIT_CNT_W'(FRAC_W);

    localparam logic [AXES-1:0][COORD_W-1:0] START_RESET = '0;
    localparam logic [AXES-1:0][COORD_W-1:0] AIM_RESET   = {32'd0, 32'd0, 32'd65536};
    localparam logic [AXES-1:0][NMAG_W-1:0]  NMAG_RESET  = {17'd0, 17'd0, UNIT};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_AIM_X   = 3'd3,
        REG_AIM_Y   = 3'd4,
        REG_AIM_Z   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        NRM_IDLE,
        NRM_COEF,
        NRM_DIV
    } nrm_state_t;

    typedef struct packed {
        logic                          busy;
        logic [AXES-1:0][COORD_W-1:0]  start;
        logic [AXES-1:0][NMAG_W-1:0]   n_mag;
        logic [AXES-1:0]               n_neg;
    } ray_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] lo;
        logic [AXES-1:0][COORD_W-1:0] hi;
    } box_t;

    typedef struct packed {
        logic [FACES-1:0]              face_en;
        logic [FACES-1:0]              q_neg;
        logic [FACES-1:0][COORD_W-1:0] num;
        box_t                          box;
    } face_job_t;

    typedef struct packed {
        logic [FACES-1:0]              face_en;
        logic [FACES-1:0]              q_neg;
        logic [FACES-1:0][NMAG_W-1:0]  rem;
        logic [FACES-1:0][DIVD_W-1:0]  dq;
        box_t                          box;
    } div_stage_t;

    typedef struct packed {
        logic           vld;
        logic [T_W-1:0] t;
    } cand_t;

    function automatic int face_axis(input int f);
        return (f < AXES) ? f : f - AXES;
    endfunction

    function automatic int other_axis(input int a, input int j);
        int s;
        s = a + 1 + j;
        return (s >= AXES) ? s - AXES : s;
    endfunction

    function automatic cand_t cand_min(input cand_t x, input cand_t y);
        if (x.vld && (!y.vld || ($signed(x.t) <= $signed(y.t))))
            return x;
        return y;
    endfunction

endpackage

FILE: rtl/rbed_cfg.sv
// ray registers and sequential direction normalizer
module rbed_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbed_pkg::COORD_W-1:0]     cfg_data,
    output rbed_pkg::ray_t                   ray
);

    logic [rbed_pkg::AXES-1:0][rbed_pkg::COORD_W-1:0] start_reg, start_next;
    logic [rbed_pkg::AXES-1:0][rbed_pkg::COORD_W-1:0] aim_reg, aim_next;
    logic [rbed_pkg::AXES-1:0][rbed_pkg::COORD_W-1:0] d_abs_reg, d_abs_next;
    logic [rbed_pkg::AXES-1:0]                        d_neg_reg, d_neg_next;
    logic [rbed_pkg::COORD_W-1:0]                     coef_reg, coef_next;
    logic [1:0]                                       axis_reg, axis_next;
    logic [rbed_pkg::BIT_CNT_W-1:0]                   bit_reg, bit_next;
    logic [rbed_pkg::COORD_W-1:0]                     rem_reg, rem_next;
    logic [rbed_pkg::NMAG_W-1:0]                      quo_reg, quo_next;
    logic [rbed_pkg::AXES-1:0][rbed_pkg::NMAG_W-1:0]  n_mag_reg, n_mag_next;
    logic [rbed_pkg::AXES-1:0]                        n_neg_reg, n_neg_next;
    rbed_pkg::nrm_state_t                             state_reg, state_next;

    logic [rbed_pkg::AXES-1:0][rbed_pkg::COORD_W-1:0] d_abs_c;
    logic [rbed_pkg::AXES-1:0]                        d_neg_c;
    logic [rbed_pkg::COORD_W-1:0]                     coef_c;
    logic [rbed_pkg::COORD_W:0]                       rr;
    logic                                             ge;
    logic [rbed_pkg::COORD_W-1:0]                     rem_step;
    logic [rbed_pkg::NMAG_W-1:0]                      quo_step;
    logic                                             cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && (cfg_index <= rbed_pkg::REG_AIM_Z);

    // direction magnitudes and largest component
    always_comb
    begin
        logic [rbed_pkg::COORD_W:0] d;
        coef_c = '0;
        for (int a = 0; a < rbed_pkg::AXES; a++)
        begin
            d = {aim_reg[a][rbed_pkg::COORD_W-1], aim_reg[a]}
              - {start_reg[a][rbed_pkg::COORD_W-1], start_reg[a]};
            d_neg_c[a] = d[rbed_pkg::COORD_W];
            d_abs_c[a] = d[rbed_pkg::COORD_W] ? rbed_pkg::COORD_W'(33'd0 - d)
                                              : d[rbed_pkg::COORD_W-1:0];
            if (d_abs_c[a] > coef_c)
                coef_c = d_abs_c[a];
        end
    end

    // one quotient bit per cycle
    always_comb
    begin
        rr = (bit_reg == rbed_pkg::TOP_BIT) ? {1'b0, d_abs_reg[axis_reg]} : {rem_reg, 1'b0};
        ge = rr >= {1'b0, coef_reg};
        rem_step = ge ? rbed_pkg::COORD_W'(rr - {1'b0, coef_reg})
                      : rr[rbed_pkg::COORD_W-1:0];
        quo_step = {quo_reg[rbed_pkg::NMAG_W-2:0], ge};
    end

    always_comb
    begin
        start_next = start_reg;
        aim_next   = aim_reg;
        d_abs_next = d_abs_reg;
        d_neg_next = d_neg_reg;
        coef_next  = coef_reg;
        axis_next  = axis_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        n_mag_next = n_mag_reg;
        n_neg_next = n_neg_reg;
        state_next = state_reg;
        unique case (state_reg)
            rbed_pkg::NRM_IDLE:
            begin
                state_next = rbed_pkg::NRM_IDLE;
            end
            rbed_pkg::NRM_COEF:
            begin
                d_abs_next = d_abs_c;
                d_neg_next = d_neg_c;
                coef_next  = coef_c;
                axis_next  = 2'd0;
                bit_next   = rbed_pkg::TOP_BIT;
                state_next = rbed_pkg::NRM_DIV;
            end
            rbed_pkg::NRM_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                if (bit_reg == '0)
                begin
                    n_mag_next[axis_reg] = (coef_reg == '0) ? '0 : quo_step;
                    n_neg_next[axis_reg] = d_neg_reg[axis_reg];
                    bit_next = rbed_pkg::TOP_BIT;
                    if (axis_reg == 2'(rbed_pkg::AXES - 1))
                        state_next = rbed_pkg::NRM_IDLE;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = rbed_pkg::NRM_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            unique case (cfg_index)
                rbed_pkg::REG_START_X: start_next[0] = cfg_data;
                rbed_pkg::REG_START_Y: start_next[1] = cfg_data;
                rbed_pkg::REG_START_Z: start_next[2] = cfg_data;
                rbed_pkg::REG_AIM_X:   aim_next[0]   = cfg_data;
                rbed_pkg::REG_AIM_Y:   aim_next[1]   = cfg_data;
                rbed_pkg::REG_AIM_Z:   aim_next[2]   = cfg_data;
                default:               aim_next      = aim_reg;
            endcase
            state_next = rbed_pkg::NRM_COEF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= rbed_pkg::START_RESET;
            aim_reg   <= rbed_pkg::AIM_RESET;
            n_mag_reg <= rbed_pkg::NMAG_RESET;
            n_neg_reg <= '0;
            axis_reg  <= '0;
            bit_reg   <= '0;
            state_reg <= rbed_pkg::NRM_IDLE;
        end
        else
        begin
            start_reg <= start_next;
            aim_reg   <= aim_next;
            n_mag_reg <= n_mag_next;
            n_neg_reg <= n_neg_next;
            axis_reg  <= axis_next;
            bit_reg   <= bit_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_abs_reg <= d_abs_next;
        d_neg_reg <= d_neg_next;
        coef_reg  <= coef_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign ray.busy  = (state_reg != rbed_pkg::NRM_IDLE);
    assign ray.start = start_reg;
    assign ray.n_mag = n_mag_reg;
    assign ray.n_neg = n_neg_reg;

endmodule

FILE: rtl/rbed_front.sv
// front end: unpacks a box word and sets up the six face divisions
module rbed_front (
    input  logic [rbed_pkg::S_TDATA_W-1:0] s_tdata,
    input  rbed_pkg::ray_t                 ray,
    output rbed_pkg::face_job_t            job
);

    always_comb
    begin
        logic [rbed_pkg::COORD_W-1:0] plane;
        logic [rbed_pkg::COORD_W-1:0] st;
        logic [rbed_pkg::COORD_W:0]   diff;
        int                           a;
        for (int i = 0; i < rbed_pkg::AXES; i++)
        begin
            job.box.lo[i] = s_tdata[rbed_pkg::COORD_W*i +: rbed_pkg::COORD_W];
            job.box.hi[i] = s_tdata[rbed_pkg::COORD_W*(i+rbed_pkg::AXES) +: rbed_pkg::COORD_W];
        end
        for (int f = 0; f < rbed_pkg::FACES; f++)
        begin
            a     = rbed_pkg::face_axis(f);
            plane = (f < rbed_pkg::AXES) ? job.box.lo[a] : job.box.hi[a];
            st    = ray.start[a];
            diff  = {plane[rbed_pkg::COORD_W-1], plane} - {st[rbed_pkg::COORD_W-1], st};
            job.num[f] = diff[rbed_pkg::COORD_W] ? rbed_pkg::COORD_W'(33'd0 - diff)
                                                 : diff[rbed_pkg::COORD_W-1:0];
            job.q_neg[f]   = diff[rbed_pkg::COORD_W] ^ ray.n_neg[a];
            job.face_en[f] = (ray.n_mag[a] != '0);
        end
    end

endmodule

FILE: rtl/rbed_fifo.sv
// short queue between front end and back end
module rbed_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rbed_pkg::face_job_t  wdata,
    input  logic                 pop,
    output rbed_pkg::face_job_t  rdata,
    output logic                 full,
    output logic                 empty
);

    rbed_pkg::face_job_t               mem_reg [rbed_pkg::FIFO_DEPTH];
    logic [rbed_pkg::FIFO_PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [rbed_pkg::FIFO_PTR_W:0]     cnt_reg;

    assign full  = (cnt_reg == (rbed_pkg::FIFO_PTR_W+1)'(rbed_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule

FILE: rtl/rbed_back.sv
// back end: pipelined face dividers, hit point test, minimum and output register
module rbed_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbed_pkg::face_job_t            job,
    input  logic                           job_vld,
    output logic                           job_pop,
    input  rbed_pkg::ray_t                 ray,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbed_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                     m_tuser
);

    localparam int NS = rbed_pkg::DIV_STAGES;
    localparam int F  = rbed_pkg::FACES;

    logic adv;

    rbed_pkg::div_stage_t dstg_reg [NS];
    rbed_pkg::div_stage_t dstg_next [NS];
    logic [NS-1:0]        dvld_reg;

    logic [F-1:0]                          mf_en_reg;
    logic [F-1:0][rbed_pkg::T_W-1:0]       mt_reg;
    logic [F-1:0][1:0][rbed_pkg::HI_W-1:0] mhi_reg;
    logic [F-1:0][1:0][rbed_pkg::NMAG_W-1:0] mlo_reg;
    logic [F-1:0][1:0]                     mneg_reg;
    rbed_pkg::box_t                        mbox_reg;
    logic                                  mvld_reg;

    logic [F-1:0]                          pf_en_reg;
    logic [F-1:0][rbed_pkg::T_W-1:0]       pt_reg;
    logic [F-1:0][1:0][rbed_pkg::P_W-1:0]  pp_reg;
    rbed_pkg::box_t                        pbox_reg;
    logic                                  pvld_reg;

    rbed_pkg::cand_t                       qc_reg [F];
    logic                                  qvld_reg;
    rbed_pkg::cand_t                       ac_reg [3];
    logic                                  avld_reg;
    rbed_pkg::cand_t                       bc_reg;
    logic                                  bvld_reg;

    logic [rbed_pkg::OUT_W-1:0]            dist_reg;
    logic                                  miss_reg;
    logic                                  out_vld_reg;

    logic [F-1:0]                          mf_en_next;
    logic [F-1:0][rbed_pkg::T_W-1:0]       mt_next;
    logic [F-1:0][1:0][rbed_pkg::HI_W-1:0] mhi_next;
    logic [F-1:0][1:0][rbed_pkg::NMAG_W-1:0] mlo_next;
    logic [F-1:0][1:0]                     mneg_next;
    logic [F-1:0][1:0][rbed_pkg::P_W-1:0]  pp_next;
    rbed_pkg::cand_t                       qc_next [F];
    rbed_pkg::cand_t                       ac_next [3];
    rbed_pkg::cand_t                       bc_next;
    logic [rbed_pkg::OUT_W-1:0]            dist_next;

    assign adv     = !out_vld_reg || m_tready;
    assign job_pop = adv && job_vld;

    // restoring division, one quotient bit per stage
    always_comb
    begin
        rbed_pkg::div_stage_t       cur;
        rbed_pkg::div_stage_t       nxt;
        logic [rbed_pkg::NMAG_W-1:0] dv;
        logic [rbed_pkg::NMAG_W:0]   r2;
        logic                        ge;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                cur.face_en = job.face_en;
                cur.q_neg   = job.q_neg;
                cur.box     = job.box;
                for (int f = 0; f < F; f++)
                begin
                    cur.rem[f] = '0;
                    cur.dq[f]  = {job.num[f], rbed_pkg::FRAC_W'(0)};
                end
            end
            else
            begin
                cur = dstg_reg[k-1];
            end
            nxt = cur;
            for (int f = 0; f < F; f++)
            begin
                dv = ray.n_mag[rbed_pkg::face_axis(f)];
                r2 = {cur.rem[f], cur.dq[f][rbed_pkg::DIVD_W-1]};
                ge = r2 >= {1'b0, dv};
                nxt.rem[f] = ge ? rbed_pkg::NMAG_W'(r2 - {1'b0, dv}) : r2[rbed_pkg::NMAG_W-1:0];
                nxt.dq[f]  = {cur.dq[f][rbed_pkg::DIVD_W-2:0], ge};
            end
            dstg_next[k] = nxt;
        end
    end

    // products for the hit point on the two other axes
    always_comb
    begin
        logic [rbed_pkg::DIVD_W-1:0] tm;
        logic [rbed_pkg::NMAG_W-1:0] nb;
        logic [32:0]                 lo_full;
        int                          a;
        int                          b;
        for (int f = 0; f < F; f++)
        begin
            a  = rbed_pkg::face_axis(f);
            tm = dstg_reg[NS-1].dq[f];
            mf_en_next[f] = dstg_reg[NS-1].face_en[f];
            mt_next[f] = dstg_reg[NS-1].q_neg[f] ? rbed_pkg::T_W'(0) - {1'b0, tm}
                                                  : {1'b0, tm};
            for (int j = 0; j < 2; j++)
            begin
                b  = rbed_pkg::other_axis(a, j);
                nb = ray.n_mag[b];
                mhi_next[f][j] = rbed_pkg::HI_W'(nb) * rbed_pkg::HI_W'(tm[rbed_pkg::DIVD_W-1:16]);
                lo_full        = 33'(nb) * 33'(tm[15:0]);
                mlo_next[f][j] = lo_full[32:16];
                mneg_next[f][j] = ray.n_neg[b] ^ dstg_reg[NS-1].q_neg[f];
            end
        end
    end

    // hit point coordinate
    always_comb
    begin
        logic [rbed_pkg::SUM_W-1:0] r;
        logic [rbed_pkg::SUM_W:0]   sc;
        logic [rbed_pkg::COORD_W-1:0] s;
        int                         b;
        for (int f = 0; f < F; f++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                b  = rbed_pkg::other_axis(rbed_pkg::face_axis(f), j);
                s  = ray.start[b];
                r  = rbed_pkg::SUM_W'(mhi_reg[f][j]) + rbed_pkg::SUM_W'(mlo_reg[f][j]);
                sc = mneg_reg[f][j] ? (rbed_pkg::SUM_W+1)'(0) - {1'b0, r} : {1'b0, r};
                pp_next[f][j] = {{(rbed_pkg::P_W-rbed_pkg::COORD_W){s[rbed_pkg::COORD_W-1]}}, s}
                              + {sc[rbed_pkg::SUM_W], sc};
            end
        end
    end

    // face qualification and minimum tree
    always_comb
    begin
        logic [rbed_pkg::P_W-1:0] lo_e;
        logic [rbed_pkg::P_W-1:0] hi_e;
        logic                     ok;
        int                       b;
        for (int f = 0; f < F; f++)
        begin
            ok = pf_en_reg[f];
            for (int j = 0; j < 2; j++)
            begin
                b    = rbed_pkg::other_axis(rbed_pkg::face_axis(f), j);
                lo_e = {{(rbed_pkg::P_W-rbed_pkg::COORD_W){pbox_reg.lo[b][rbed_pkg::COORD_W-1]}},
                        pbox_reg.lo[b]};
                hi_e = {{(rbed_pkg::P_W-rbed_pkg::COORD_W){pbox_reg.hi[b][rbed_pkg::COORD_W-1]}},
                        pbox_reg.hi[b]};
                if (($signed(pp_reg[f][j]) < $signed(lo_e)) ||
                    ($signed(pp_reg[f][j]) >= $signed(hi_e)))
                    ok = 1'b0;
            end
            qc_next[f].vld = ok;
            qc_next[f].t   = pt_reg[f];
        end
        for (int i = 0; i < 3; i++)
            ac_next[i] = rbed_pkg::cand_min(qc_reg[2*i], qc_reg[2*i+1]);
        bc_next = rbed_pkg::cand_min(rbed_pkg::cand_min(ac_reg[0], ac_reg[1]), ac_reg[2]);
    end

    // clamp into the output range
    always_comb
    begin
        if (!bc_reg.vld)
            dist_next = rbed_pkg::SENTINEL;
        else if (bc_reg.t[rbed_pkg::T_W-1])
            dist_next = '0;
        else if (bc_reg.t > rbed_pkg::T_W'(rbed_pkg::SENTINEL))
            dist_next = rbed_pkg::SENTINEL;
        else
            dist_next = bc_reg.t[rbed_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg    <= '0;
            mvld_reg    <= 1'b0;
            pvld_reg    <= 1'b0;
            qvld_reg    <= 1'b0;
            avld_reg    <= 1'b0;
            bvld_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            dvld_reg    <= {dvld_reg[NS-2:0], job_vld};
            mvld_reg    <= dvld_reg[NS-1];
            pvld_reg    <= mvld_reg;
            qvld_reg    <= pvld_reg;
            avld_reg    <= qvld_reg;
            bvld_reg    <= avld_reg;
            out_vld_reg <= bvld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++)
                dstg_reg[k] <= dstg_next[k];
            mf_en_reg <= mf_en_next;
            mt_reg    <= mt_next;
            mhi_reg   <= mhi_next;
            mlo_reg   <= mlo_next;
            mneg_reg  <= mneg_next;
            mbox_reg  <= dstg_reg[NS-1].box;
            pf_en_reg <= mf_en_reg;
            pt_reg    <= mt_reg;
            pp_reg    <= pp_next;
            pbox_reg  <= mbox_reg;
            for (int f = 0; f < F; f++)
                qc_reg[f] <= qc_next[f];
            for (int i = 0; i < 3; i++)
                ac_reg[i] <= ac_next[i];
            bc_reg    <= bc_next;
            dist_reg  <= dist_next;
            miss_reg  <= !bc_reg.vld;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(rbed_pkg::M_TDATA_W-rbed_pkg::OUT_W)'(0), dist_reg};
    assign m_tuser  = miss_reg;

endmodule

FILE: rtl/ray_box_entry_distance_top.sv
// top level of the ray box entry distance block
//
// A ray is set through the cfg channel: index 0..2 write the start point, 3..5 the
// aim point, all signed Q16.16. Each write starts a normalization of the direction,
// one quotient bit a cycle in a shared divider; s_tready is low meanwhile. Reset
// loads start (0,0,0) and aim (1,0,0) with the direction ready. Each s_tdata word
// is one box; the m_tdata word returns the entry distance and m_tuser flags a miss.
// One box is accepted per cycle while s_tready is high. A box passes the queue, a
// 48 stage pipelined divider per face (one quotient bit a stage), multiply, hit
// point, face test, a two level minimum tree and the output register. A stalled
// receiver freezes the back pipeline; a four word queue after the front end keeps
// s_tready high until it fills. Configuration must be written only while no box
// is in flight; the block itself does not enforce this.
module ray_box_entry_distance_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z
    input  logic [rbed_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // entry_distance, zero pad
    output logic [rbed_pkg::M_TDATA_W-1:0]   m_tdata,
    // missed
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbed_pkg::COORD_W-1:0]     cfg_data
);

    rbed_pkg::ray_t      ray;
    rbed_pkg::face_job_t front_job;
    rbed_pkg::face_job_t back_job;
    logic                fifo_full;
    logic                fifo_empty;
    logic                job_pop;
    logic                push;

    assign s_tready = !fifo_full && !ray.busy;
    assign push     = s_tvalid && s_tready;

    rbed_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ray       (ray)
    );

    rbed_front u_front (
        .s_tdata (s_tdata),
        .ray     (ray),
        .job     (front_job)
    );

    rbed_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .pop   (job_pop),
        .rdata (back_job),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    rbed_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (back_job),
        .job_vld  (!fifo_empty),
        .job_pop  (job_pop),
        .ray      (ray),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/rbed_checker.sv
// port level checks for the ray box entry distance block
module rbed_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rbed_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rbed_pkg::CFG_IDX_W-1:0]   cfg_index
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    // a miss always carries the sentinel
    a_miss_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[rbed_pkg::OUT_W-1:0] == rbed_pkg::SENTINEL)
        else $error("miss without sentinel");

    // distance stays in range and pad bits are zero
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[rbed_pkg::OUT_W-1:0] <= rbed_pkg::SENTINEL) &&
                     (m_tdata[rbed_pkg::M_TDATA_W-1:rbed_pkg::OUT_W] == '0))
        else $error("distance out of range");

    // ray write blocks boxes while the direction is renormalized
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= rbed_pkg::REG_AIM_Z) |=> !s_tready)
        else $error("box accepted during normalization");

endmodule

bind ray_box_entry_distance_top rbed_checker u_rbed_checker (.*);

FILE: verif/tb_top.sv
// testbench for the ray box entry distance block: directed boxes, then random boxes per ray
`timescale 1ns / 1ps

module tb_top;

    localparam longint ONE      = 65536;
    localparam longint CAP      = 104857600;
    localparam int     N_PHASES = 8;
    localparam int     N_RAND   = 60;

    typedef struct {
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } box_s;

    typedef struct {
        logic [26:0] distance;
        logic        miss;
    } hit_s;

    typedef struct {
        box_s b;
        bit   known;
        hit_s want;
    } row_s;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [rbed_pkg::S_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [rbed_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [rbed_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rbed_pkg::COORD_W-1:0] cfg_data;

    logic [31:0] ray_reg [6];
    hit_s pending [$];
    int errors;
    int mode;
    bit done;

    ray_box_entry_distance_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // idle percentage of the current phase
    function automatic int idle_pct();
        return (mode == 3) ? 24 : 77;
    endfunction

    // unit-normalized direction of the current ray
    function automatic void ray_dir(output longint n [3]);
        longint d [3];
        longint coef;
        coef = 0;
        for (int a = 0; a < 3; a++)
        begin
            d[a] = sx(ray_reg[a + 3]) - sx(ray_reg[a]);
            if (absl(d[a]) > coef)
                coef = absl(d[a]);
        end
        for (int a = 0; a < 3; a++)
            n[a] = (coef != 0) ? (d[a] * ONE) / coef : 0;
    endfunction

    function automatic longint scale_by(input longint n, input longint t);
        longint unsigned a, m, r;
        a = absl(n);
        m = absl(t);
        r = a * (m >> 16) + ((a * (m & 64'hFFFF)) >> 16);
        return ((n < 0) != (t < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic hit_s entry_distance(input box_s b);
        longint n [3];
        longint lo, hi, plane, t, p, best;
        bit found, ok;
        hit_s h;
        ray_dir(n);
        found = 0;
        best = 0;
        for (int a = 0; a < 3; a++)
        begin
            if (n[a] == 0)
                continue;
            for (int k = 0; k < 2; k++)
            begin
                plane = k ? sx(b.hi[a]) : sx(b.lo[a]);
                t = ((plane - sx(ray_reg[a])) * ONE) / n[a];
                ok = 1;
                for (int c = 0; c < 3; c++)
                begin
                    if (c == a)
                        continue;
                    p = sx(ray_reg[c]) + scale_by(n[c], t);
                    lo = sx(b.lo[c]);
                    hi = sx(b.hi[c]);
                    if (p < lo || p >= hi)
                        ok = 0;
                end
                if (ok && (!found || t < best))
                begin
                    best = t;
                    found = 1;
                end
            end
        end
        if (!found)
        begin
            h.distance = 27'(CAP);
            h.miss = 1'b1;
        end
        else
        begin
            if (best < 0)
                best = 0;
            if (best > CAP)
                best = CAP;
            h.distance = 27'(best);
            h.miss = 1'b0;
        end
        return h;
    endfunction

    function automatic box_s mk_box(input longint lx, input longint ly, input longint lz,
                                    input longint hx, input longint hy, input longint hz);
        box_s b;
        b.lo[0] = 32'(lx); b.lo[1] = 32'(ly); b.lo[2] = 32'(lz);
        b.hi[0] = 32'(hx); b.hi[1] = 32'(hy); b.hi[2] = 32'(hz);
        return b;
    endfunction

    function automatic box_s rand_box();
        box_s b;
        longint n [3];
        longint t, c, h;
        if ($urandom_range(0, 99) < 20)
        begin
            for (int a = 0; a < 3; a++)
            begin
                b.lo[a] = $urandom;
                b.hi[a] = $urandom;
            end
            return b;
        end
        ray_dir(n);
        t = longint'($urandom_range(0, 1700 * 65536)) - longint'($urandom_range(0, 20 * 65536));
        if ($urandom_range(0, 3) == 0)
            t = $urandom_range(0, 50 * 65536);
        for (int a = 0; a < 3; a++)
        begin
            c = sx(ray_reg[a]) + scale_by(n[a], t);
            h = $urandom_range(0, 8 * 65536);
            case ($urandom_range(0, 5))
                0: b.lo[a] = 32'(c);
                1: b.hi[a] = 32'(c);
                default: ;
            endcase
            if ($urandom_range(0, 5) > 1)
            begin
                b.lo[a] = 32'(c - h);
                b.hi[a] = 32'(c + longint'($urandom_range(0, 8 * 65536)));
            end
            else if ($urandom_range(0, 1))
            begin
                b.lo[a] = 32'(c);
                b.hi[a] = 32'(c + h);
            end
            else
            begin
                b.lo[a] = 32'(c - h);
                b.hi[a] = 32'(c);
            end
        end
        return b;
    endfunction

    task automatic send_box(input box_s b);
        while (mode[0] && $urandom_range(0, 99) < idle_pct())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.hi[2], b.hi[1], b.hi[0], b.lo[2], b.lo[1], b.lo[0]};
        do
            @(posedge clk);
        while (!s_tready);
        pending.push_back(entry_distance(b));
    endtask

    task automatic write_reg(input int idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= rbed_pkg::cfg_reg_t'(idx);
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ray_reg[idx] = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !(mode[1] && $urandom_range(0, 99) < idle_pct());
    end

    always @(posedge clk)
    begin
        hit_s w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word dist=%0d miss=%0b", m_tdata[26:0], m_tuser[0]);
            end
            else
            begin
                w = pending.pop_front();
                if (m_tdata[26:0] !== w.distance || m_tuser[0] !== w.miss
                    || m_tdata[31:27] !== 5'd0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected dist=%0d miss=%0b, got word=%h miss=%0b",
                                 w.distance, w.miss, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    initial
    begin
        row_s rows [$];
        row_s r;
        logic [31:0] ray [6];
        hit_s g;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rbed_pkg::REG_START_X;
        cfg_data  = '0;
        errors    = 0;
        mode      = 0;
        done      = 0;
        ray_reg   = '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ray: from origin along +x
        r.known = 1;
        g.miss = 0;
        g.distance = 27'(ONE);
        r.b = mk_box(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE);           r.want = g; rows.push_back(r);
        r.b = mk_box(ONE, 0, -ONE, 2 * ONE, ONE, ONE);              r.want = g; rows.push_back(r);
        g.distance = 0;
        r.b = mk_box(-3 * ONE, -ONE, -ONE, -2 * ONE, ONE, ONE);     r.want = g; rows.push_back(r);
        r.b = mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);              r.want = g; rows.push_back(r);
        g.distance = 27'(CAP);
        r.b = mk_box(2000 * ONE, -ONE, -ONE, 2001 * ONE, ONE, ONE); r.want = g; rows.push_back(r);
        g.miss = 1;
        r.b = mk_box(ONE, ONE, -ONE, 2 * ONE, -ONE, ONE);           r.want = g; rows.push_back(r);
        r.b = mk_box(ONE, -ONE, -ONE, 2 * ONE, 0, ONE);             r.want = g; rows.push_back(r);
        r.known = 0;
        r.b = mk_box(-2147483648, -2147483648, -2147483648,
                     -2147483648, -2147483648, -2147483648);       rows.push_back(r);
        r.b = mk_box(2147483647, 2147483647, 2147483647,
                     2147483647, 2147483647, 2147483647);          rows.push_back(r);
        r.b = mk_box(-2147483648, -2147483648, -2147483648,
                     2147483647, 2147483647, 2147483647);          rows.push_back(r);
        r.b = mk_box(32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                     32'h55555555, 32'h55555555, 32'h55555555);    rows.push_back(r);
        r.b = mk_box(32'h55555555, 32'h55555555, 32'h55555555,
                     32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA);    rows.push_back(r);

        foreach (rows[i])
        begin
            send_box(rows[i].b);
            if (rows[i].known)
            begin
                g = pending.pop_back();
                pending.push_back(rows[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                for (int i = 0; i < 6; i++)
                    ray[i] = 32'(longint'($urandom_range(0, 40 * 65536)) - 20 * ONE);
                case (ph)
                    1: ray = '{32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
                    2: ray = '{32'h7FFFFFFF, 32'h0, 32'h80000000,
                               32'h80000000, 32'h0, 32'h7FFFFFFF};
                    3: for (int i = 0; i < 3; i++) ray[i + 3] = ray[i];
                    4: begin ray[4] = ray[1]; ray[5] = ray[2]; ray[3] = ray[0] - 32'd1; end
                    5: begin ray[3] = ray[0]; ray[5] = ray[2]; end
                    default: ;
                endcase
                for (int i = 0; i < 6; i++)
                    write_reg(i, ray[i]);
                cfg_valid <= 1'b0;
            end
            mode = ph % 4;
            for (int k = 0; k < N_RAND; k++)
                send_box(rand_box());
        end
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        done = 1;
        if (errors == 0)
            $display("ray_box_entry_distance_top verification clean");
        else
            $display("ray_box_entry_distance_top verification failed");
        $finish;
    end

    initial
    begin
        #4ms;
        if (!done)
        begin
            $display("ray_box_entry_distance_top verification failed");
            $finish;
        end
    end

endmodule
